### rtl/tga_pkg.sv
`default_nettype none
package tga_pkg;

  // image limits and storage sizes
  localparam int unsigned HdrLen   = 18;
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned MinWidth = 4;
  localparam int unsigned PalDepth = 256;
  localparam int unsigned QDepth   = 4;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SIZE   = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  // command from the parser to the segment writer
  // size: row = height, col = width; pixel: n pixels of argb
  typedef struct packed {
    kind_e       kind;
    logic [12:0] row;
    logic [12:0] col;
    logic [7:0]  n;
    logic [31:0] argb;
    logic        flip;
    logic        last;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/tga_image_decoder.sv
`default_nettype none
// TGA decoder: takes a TGA file one byte per transfer (tlast on the final byte)
// and returns a size item, then pixel segments (equal ARGB pixels within one
// destination row), and finally a done or reject item (a bad header gives a
// reject item alone); types 1, 2, 9 and 10 at 24 or 32 bits are handled. The
// input is held while a byte's results are pushed; a palette-indexed pixel
// first passes a lookup state (registered palette read); the segment writer
// splits a repeat run that crosses rows into one segment per row. Parser and
// segment writer are decoupled by a four-entry command queue. Per-entry valid
// bits clear the palette, so no clearing pass is needed after reset or file end.
module tga_image_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // row, column, run_length, argb, zero pad
  output logic [1:0]       m_axis_tuser_o,   // kind
  output logic             m_axis_tlast_o    // last item produced for one input byte
);
  import tga_pkg::*;

  cmd_t           f_cmd, q_cmd;
  logic           f_valid, f_ready, q_valid, q_ready;
  kind_e          o_kind;
  logic [12:0]    o_row, o_col;
  logic [7:0]     o_run;
  logic [31:0]    o_argb;

  tga_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid_i),
    .byte_ready_o(s_axis_tready_o),
    .byte_data_i (s_axis_tdata_i),
    .byte_last_i (s_axis_tlast_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready)
  );

  tga_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (f_cmd),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .pop_data_o  (q_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready)
  );

  tga_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_kind_o (o_kind),
    .out_row_o  (o_row),
    .out_col_o  (o_col),
    .out_run_o  (o_run),
    .out_argb_o (o_argb),
    .out_last_o (m_axis_tlast_o)
  );

  // result packing
  assign m_axis_tdata_o = {6'd0, o_argb, o_run, o_col, o_row};
  assign m_axis_tuser_o = o_kind;

endmodule
`default_nettype wire

### rtl/tga_cmd_fifo.sv
`default_nettype none
module tga_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tga_pkg::cmd_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output tga_pkg::cmd_t      pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);
  import tga_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/tga_front.sv
`default_nettype none
module tga_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_valid_i,
  output logic               byte_ready_o,
  input  wire logic [7:0]    byte_data_i,
  input  wire logic          byte_last_i,
  output tga_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);
  import tga_pkg::*;

  // parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_PACKET  = 3'd2;
  localparam logic [2:0] PH_PIXEL   = 3'd3;
  localparam logic [2:0] PH_FIN     = 3'd4;

  // control states
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_LOOK = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  // image types
  localparam logic [7:0] TYPE_MAP     = 8'd1;
  localparam logic [7:0] TYPE_TRUE    = 8'd2;
  localparam logic [7:0] TYPE_MAP_RLE = 8'd9;
  localparam logic [7:0] TYPE_TRU_RLE = 8'd10;

  localparam logic [31:0] AlphaOpaque = 32'hFF00_0000;

  logic [7:0]  hdr_q [HdrLen];
  logic [7:0]  hdr_d [HdrLen];
  logic [4:0]  hcnt_q, hcnt_d;
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  fsm_q, fsm_d;
  logic [7:0]  pidx_q, pidx_d;
  logic [9:0]  pcnt_q, pcnt_d;
  logic [9:0]  ptot_q, ptot_d;
  logic [31:0] asm_q, asm_d;
  logic [1:0]  bip_q, bip_d;
  logic [7:0]  rem_q, rem_d;
  logic        rep_q, rep_d;
  logic [25:0] done_q, done_d;
  logic [25:0] total_q;
  logic        llast_q, llast_d;
  cmd_t        pend_q [2];
  cmd_t        pend_d [2];
  logic [1:0]  pcnt2_q, pcnt2_d;

  // palette memory with per-entry valid bits
  logic [31:0]         pal_mem [PalDepth];
  logic [PalDepth-1:0] vld_q;
  logic [31:0]         rd_q;
  logic                rd_vld_q;
  logic                wr_en, vld_clr;
  logic [31:0]         wr_data;

  // header decode
  logic [7:0]  typ;
  logic [15:0] wv, hv;
  logic        mapped, rle, truecol, ok_m, ok_t, dim_ok, hdr_ok, flip;
  logic [2:0]  eb, pb;
  logic [9:0]  ptot_new;

  // per-byte work
  logic        acc, lst, comp_en, do_last;
  logic [31:0] asm_new, comp_argb;
  logic [7:0]  n_req, take;
  logic [25:0] remain, done_new;
  cmd_t        cmds [2];
  logic [1:0]  ncmd;

  assign typ     = hdr_q[2];
  assign wv      = {hdr_q[13], hdr_q[12]};
  assign hv      = {hdr_q[15], hdr_q[14]};
  assign mapped  = (typ == TYPE_MAP) || (typ == TYPE_MAP_RLE);
  assign truecol = (typ == TYPE_TRUE) || (typ == TYPE_TRU_RLE);
  assign rle     = (typ == TYPE_MAP_RLE) || (typ == TYPE_TRU_RLE);
  assign eb      = hdr_q[7][5:3];
  assign pb      = mapped ? 3'd1 : hdr_q[16][5:3];
  assign flip    = (hdr_q[10] == 8'd0) && (hdr_q[11] == 8'd0);
  assign ok_m    = mapped && (hdr_q[6] == 8'd0) && (hdr_q[4] == 8'd0) && (hdr_q[3] == 8'd0)
                   && ((hdr_q[7] == 8'd24) || (hdr_q[7] == 8'd32));
  assign ok_t    = truecol && (hdr_q[5] == 8'd0) && (hdr_q[6] == 8'd0) && (hdr_q[1] == 8'd0)
                   && ((hdr_q[16] == 8'd24) || (hdr_q[16] == 8'd32));
  assign dim_ok  = (wv >= 16'(MinWidth)) && (wv <= 16'(MaxDim))
                   && (hv != 16'd0) && (hv <= 16'(MaxDim));
  assign hdr_ok  = (ok_m || ok_t) && dim_ok;
  assign ptot_new = (hdr_q[1] != 8'd0) ? (10'(hdr_q[5]) * 10'(eb)) : 10'd0;

  assign byte_ready_o = (fsm_q == F_IDLE);
  assign acc          = byte_valid_i && byte_ready_o;
  assign cmd_o        = pend_q[0];
  assign cmd_valid_o  = (fsm_q == F_PUSH);

  // pixel count of the image, one multiply registered
  always_ff @(posedge clk_i) begin
    total_q <= 26'(wv[12:0]) * 26'(hv[12:0]);
  end

  // byte parsing, pixel completion and end-of-file handling
  always_comb begin
    hdr_d    = hdr_q;
    hcnt_d   = hcnt_q;
    phase_d  = phase_q;
    fsm_d    = fsm_q;
    pidx_d   = pidx_q;
    pcnt_d   = pcnt_q;
    ptot_d   = ptot_q;
    asm_d    = asm_q;
    bip_d    = bip_q;
    rem_d    = rem_q;
    rep_d    = rep_q;
    done_d   = done_q;
    llast_d  = llast_q;
    pend_d   = pend_q;
    pcnt2_d  = pcnt2_q;
    wr_en    = 1'b0;
    wr_data  = '0;
    vld_clr  = 1'b0;
    comp_en  = 1'b0;
    comp_argb = '0;
    do_last  = 1'b0;
    lst      = 1'b0;
    cmds[0]  = '0;
    cmds[1]  = '0;
    ncmd     = '0;
    n_req    = '0;
    take     = '0;
    remain   = '0;
    done_new = '0;
    asm_new  = asm_q | (32'(byte_data_i) << {bip_q, 3'b000});

    case (fsm_q)
      F_IDLE: begin
        if (acc) begin
          lst     = byte_last_i;
          do_last = 1'b1;
          case (phase_q)
            PH_HEADER: begin
              hdr_d[hcnt_q] = byte_data_i;
              hcnt_d = hcnt_q + 1'b1;
              if (hcnt_q == 5'(HdrLen - 1)) begin
                if (!hdr_ok) begin
                  cmds[ncmd[0]].kind = KIND_REJECT;
                  ncmd = ncmd + 1'b1;
                  phase_d = PH_FIN;
                end else begin
                  cmds[ncmd[0]].kind = KIND_SIZE;
                  cmds[ncmd[0]].row  = hv[12:0];
                  cmds[ncmd[0]].col  = wv[12:0];
                  cmds[ncmd[0]].flip = flip;
                  ncmd = ncmd + 1'b1;
                  ptot_d = ptot_new;
                  pidx_d = '0;
                  pcnt_d = '0;
                  bip_d  = '0;
                  asm_d  = '0;
                  done_d = '0;
                  if (ptot_new != 10'd0) phase_d = PH_PALETTE;
                  else phase_d = rle ? PH_PACKET : PH_PIXEL;
                end
              end
            end
            PH_PALETTE: begin
              if ({1'b0, bip_q} + 3'd1 >= eb) begin
                wr_en   = 1'b1;
                wr_data = asm_new | ((eb == 3'd3) ? AlphaOpaque : 32'd0);
                pidx_d  = pidx_q + 1'b1;
                asm_d   = '0;
                bip_d   = '0;
              end else begin
                asm_d = asm_new;
                bip_d = bip_q + 1'b1;
              end
              pcnt_d = pcnt_q + 1'b1;
              if ({1'b0, pcnt_q} + 11'd1 >= {1'b0, ptot_q}) begin
                phase_d = rle ? PH_PACKET : PH_PIXEL;
                asm_d   = '0;
                bip_d   = '0;
              end
            end
            PH_PACKET: begin
              if (byte_data_i > 8'd127) begin
                rep_d = 1'b1;
                rem_d = byte_data_i - 8'd127;
              end else begin
                rep_d = 1'b0;
                rem_d = byte_data_i + 8'd1;
              end
              phase_d = PH_PIXEL;
              asm_d   = '0;
              bip_d   = '0;
            end
            PH_PIXEL: begin
              if ({1'b0, bip_q} + 3'd1 >= pb) begin
                asm_d = '0;
                bip_d = '0;
                if (mapped) begin
                  fsm_d   = F_LOOK;
                  llast_d = byte_last_i;
                  do_last = 1'b0;
                end else begin
                  comp_en   = 1'b1;
                  comp_argb = asm_new | ((pb == 3'd3) ? AlphaOpaque : 32'd0);
                end
              end else begin
                asm_d = asm_new;
                bip_d = bip_q + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      F_LOOK: begin
        comp_en   = 1'b1;
        comp_argb = rd_vld_q ? rd_q : 32'd0;
        lst       = llast_q;
        do_last   = 1'b1;
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          if (pcnt2_q == 2'd2) begin
            pend_d[0] = pend_q[1];
            pcnt2_d   = 2'd1;
          end else begin
            pcnt2_d = 2'd0;
            fsm_d   = F_IDLE;
          end
        end
      end
      default: fsm_d = F_IDLE;
    endcase

    // deliver one completed pixel value (a whole repeat run in RLE), clipped at the image end
    if (comp_en) begin
      n_req    = (rle && rep_q) ? rem_q : 8'd1;
      remain   = total_q - done_q;
      take     = (26'(n_req) < remain) ? n_req : remain[7:0];
      done_new = done_q + 26'(take);
      done_d   = done_new;
      cmds[ncmd[0]].kind = KIND_PIXEL;
      cmds[ncmd[0]].n    = take;
      cmds[ncmd[0]].argb = comp_argb;
      ncmd = ncmd + 1'b1;
      if (done_new == total_q) begin
        cmds[ncmd[0]].kind = KIND_DONE;
        ncmd = ncmd + 1'b1;
        phase_d = PH_FIN;
      end else if (rle) begin
        if (rep_q) begin
          phase_d = PH_PACKET;
        end else begin
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) phase_d = PH_PACKET;
        end
      end
    end

    // final byte of the file: close the image and restart
    if (do_last && lst) begin
      if (phase_d != PH_FIN) begin
        cmds[ncmd[0]].kind = ((phase_d != PH_HEADER) && rle) ? KIND_DONE : KIND_REJECT;
        ncmd = ncmd + 1'b1;
      end
      for (int i = 0; i < HdrLen; i++) hdr_d[i] = '0;
      hcnt_d  = '0;
      phase_d = PH_HEADER;
      pidx_d  = '0;
      pcnt_d  = '0;
      ptot_d  = '0;
      asm_d   = '0;
      bip_d   = '0;
      rem_d   = '0;
      rep_d   = 1'b0;
      done_d  = '0;
      vld_clr = 1'b1;
    end

    // hand the results of this byte to the push stage
    if (ncmd != 2'd0) begin
      cmds[ncmd[1]].last = 1'b1;
      pend_d[0] = cmds[0];
      pend_d[1] = cmds[1];
      pcnt2_d   = ncmd;
      fsm_d     = F_PUSH;
    end else if (fsm_q == F_LOOK) begin
      fsm_d = F_IDLE;
    end
  end

  // palette storage and registered lookup
  always_ff @(posedge clk_i) begin
    if (wr_en) pal_mem[pidx_q] <= wr_data;
    rd_q <= pal_mem[byte_data_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[byte_data_i];
      if (vld_clr) vld_q <= '0;
      else if (wr_en) vld_q[pidx_q] <= 1'b1;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
      hcnt_q  <= '0;
      phase_q <= PH_HEADER;
      fsm_q   <= F_IDLE;
      pidx_q  <= '0;
      pcnt_q  <= '0;
      ptot_q  <= '0;
      asm_q   <= '0;
      bip_q   <= '0;
      rem_q   <= '0;
      rep_q   <= 1'b0;
      done_q  <= '0;
      llast_q <= 1'b0;
      pcnt2_q <= '0;
    end else begin
      hdr_q   <= hdr_d;
      hcnt_q  <= hcnt_d;
      phase_q <= phase_d;
      fsm_q   <= fsm_d;
      pidx_q  <= pidx_d;
      pcnt_q  <= pcnt_d;
      ptot_q  <= ptot_d;
      asm_q   <= asm_d;
      bip_q   <= bip_d;
      rem_q   <= rem_d;
      rep_q   <= rep_d;
      done_q  <= done_d;
      llast_q <= llast_d;
      pcnt2_q <= pcnt2_d;
    end
  end

  // pending commands
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule
`default_nettype wire

### rtl/tga_back.sv
`default_nettype none
module tga_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tga_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tga_pkg::kind_e     out_kind_o,
  output logic [12:0]        out_row_o,
  output logic [12:0]        out_col_o,
  output logic [7:0]         out_run_o,
  output logic [31:0]        out_argb_o,
  output logic               out_last_o
);
  import tga_pkg::*;

  logic        busy_q;
  logic [12:0] w_q, h_q, row_q, col_q;
  logic        flip_q, last_q;
  logic [7:0]  n_q;
  logic [31:0] argb_q;

  logic        ov_q, olast_q;
  kind_e       okind_q;
  logic [12:0] orow_q, ocol_q;
  logic [7:0]  orun_q;
  logic [31:0] oargb_q;

  logic        can_load, pop, seg_go;
  logic [12:0] avail, dest, col_next;
  logic [7:0]  seg, n_next;

  assign can_load    = !ov_q || out_ready_i;
  assign cmd_ready_o = !busy_q && can_load;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign seg_go      = busy_q && can_load;

  // segment split at the row end
  assign avail    = w_q - col_q;
  assign seg      = (13'(n_q) < avail) ? n_q : avail[7:0];
  assign dest     = flip_q ? (h_q - 13'd1 - row_q) : row_q;
  assign col_next = col_q + 13'(seg);
  assign n_next   = n_q - seg;

  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign out_run_o   = orun_q;
  assign out_argb_o  = oargb_q;
  assign out_last_o  = olast_q;

  // working command and row position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop) begin
        case (cmd_i.kind)
          KIND_PIXEL: begin
            busy_q <= 1'b1;
            ov_q   <= 1'b0;
          end
          KIND_SIZE: begin
            row_q <= '0;
            col_q <= '0;
            ov_q  <= 1'b1;
          end
          default: ov_q <= 1'b1;
        endcase
      end else if (seg_go) begin
        ov_q   <= 1'b1;
        busy_q <= (n_next != 8'd0);
        if (col_next >= w_q) begin
          col_q <= '0;
          row_q <= row_q + 13'd1;
        end else begin
          col_q <= col_next;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      n_q     <= cmd_i.n;
      argb_q  <= cmd_i.argb;
      last_q  <= cmd_i.last;
      okind_q <= cmd_i.kind;
      orow_q  <= cmd_i.row;
      ocol_q  <= cmd_i.col;
      orun_q  <= '0;
      oargb_q <= '0;
      olast_q <= cmd_i.last;
      if (cmd_i.kind == KIND_SIZE) begin
        w_q    <= cmd_i.col;
        h_q    <= cmd_i.row;
        flip_q <= cmd_i.flip;
      end
    end else if (seg_go) begin
      n_q     <= n_next;
      okind_q <= KIND_PIXEL;
      orow_q  <= dest;
      ocol_q  <= col_q;
      orun_q  <= seg;
      oargb_q <= argb_q;
      olast_q <= last_q && (n_next == 8'd0);
    end
  end

`ifndef SYNTH
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && okind_q == KIND_PIXEL |-> orun_q != 8'd0)
    else $error("pixel segment with empty run");
  a_seg_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && okind_q == KIND_PIXEL |-> (14'(ocol_q) + 14'(orun_q)) <= 14'(w_q))
    else $error("segment crosses row end");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> n_q != 8'd0)
    else $error("busy with no pixels left");
`endif

endmodule
`default_nettype wire
